// ===== design/rmrle_pkg.sv =====
// ----------------------------------------------------------------------------
// Run/literal byte encoder package
// Shared types, constants and helper functions for the encoder blocks.
// ----------------------------------------------------------------------------
package rmrle_pkg;

  // Record control byte fields
  localparam logic [7:0] RUN_FLAG  = 8'h80;
  localparam logic [6:0] CTRL_MASK = 7'h7f;

  // Marker for "no byte seen" in the history registers
  localparam logic [8:0] NONE_MARK = 9'h100;

  // Length counters and store row numbers; lengths never exceed 130
  localparam int LEN_W = 8;
  localparam int ROW_W = LEN_W - 2;

  // Command queue depth (a power of two)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Number of store banks, one byte lane each
  localparam int NBANKS = 4;

  typedef enum logic {
    CMD_RUN,
    CMD_LIT
  } cmd_kind_e;

  // One record to be written out by the back end
  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       ctrl;  // control byte of the record
    logic [7:0]       data;  // repeated byte of a run
    logic [LEN_W-1:0] len;   // byte count of a literal
  } cmd_t;

  // Store write port driven by the front end
  typedef struct packed {
    logic [NBANKS-1:0] we;
    logic [ROW_W-1:0]  row;
    logic [7:0]        data;
  } store_wr_t;

  // Control byte of a run record of the given length (3 or more)
  function automatic logic [7:0] run_ctrl(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] diff;
    diff = len - LEN_W'(3);
    return RUN_FLAG | {1'b0, diff[6:0] & CTRL_MASK};
  endfunction

  // Control byte of a literal record of the given length (1 or more)
  function automatic logic [7:0] lit_ctrl(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] diff;
    diff = len - LEN_W'(1);
    return {1'b0, diff[6:0] & CTRL_MASK};
  endfunction

endpackage

// ===== design/rmrle_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module rmrle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rmrle_front.sv =====
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts bytes and flush commands, tracks run/literal mode, writes the
// literal store and queues one record command per finished record.
// ----------------------------------------------------------------------------
module rmrle_front #(
  parameter int LITERAL_MAX = 128,
  parameter int RUN_MAX     = 130
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_func_i,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rmrle_pkg::cmd_t     q_cmd_o,
  input  logic                lit_done_i,
  output rmrle_pkg::store_wr_t wr_o
);
  import rmrle_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LIT,
    MODE_RUN
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [8:0]       recent_q, recent_d;
  logic [8:0]       earlier_q, earlier_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             lit_busy_q, lit_busy_d;

  logic             accept;
  logic [8:0]       in_ext;
  logic [LEN_W-1:0] len_inc;

  // The store must not change while a literal record is being read out.
  assign in_ready_o = !q_full_i && !lit_busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ext     = {1'b0, in_byte_i};
  assign len_inc    = len_q + LEN_W'(1);

  // Next state, store write and record command for the accepted item
  always_comb begin
    mode_d          = mode_q;
    recent_d        = recent_q;
    earlier_d       = earlier_q;
    len_d           = len_q;
    q_push_o        = 1'b0;
    q_cmd_o.kind    = CMD_RUN;
    q_cmd_o.ctrl    = run_ctrl(len_q);
    q_cmd_o.data    = recent_q[7:0];
    q_cmd_o.len     = len_q;
    wr_o.we         = '0;
    wr_o.row        = len_q[LEN_W-1:2];
    wr_o.data       = in_byte_i;

    if (accept) begin
      if (in_func_i) begin
        // Flush: emit whatever is pending and return to idle.
        unique case (mode_q)
          MODE_RUN: begin
            q_push_o = 1'b1;
          end
          MODE_LIT: begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = CMD_LIT;
            q_cmd_o.ctrl = lit_ctrl(len_q);
          end
          default: begin
          end
        endcase
        mode_d    = MODE_IDLE;
        recent_d  = NONE_MARK;
        earlier_d = NONE_MARK;
      end else begin
        unique case (mode_q)
          MODE_RUN: begin
            if (in_ext != recent_q) begin
              // Run broken: emit it and start a literal with this byte.
              q_push_o   = 1'b1;
              mode_d     = MODE_LIT;
              wr_o.we[0] = 1'b1;
              wr_o.row   = '0;
              recent_d   = in_ext;
              len_d      = LEN_W'(1);
            end else begin
              len_d = len_inc;
              if (len_inc >= LEN_W'(RUN_MAX)) begin
                // Longest run reached.
                q_push_o     = 1'b1;
                q_cmd_o.ctrl = run_ctrl(len_inc);
                mode_d       = MODE_IDLE;
                recent_d     = NONE_MARK;
                earlier_d    = NONE_MARK;
              end
            end
          end
          MODE_LIT: begin
            if (in_ext == recent_q && in_ext == earlier_q) begin
              // Third equal byte: the last two stored bytes open a run.
              mode_d = MODE_RUN;
              if (len_q > LEN_W'(2)) begin
                q_push_o     = 1'b1;
                q_cmd_o.kind = CMD_LIT;
                q_cmd_o.len  = len_q - LEN_W'(2);
                q_cmd_o.ctrl = lit_ctrl(len_q - LEN_W'(2));
              end
              len_d = LEN_W'(3);
            end else begin
              earlier_d = recent_q;
              recent_d  = in_ext;
              wr_o.we[len_q[1:0]] = 1'b1;
              len_d     = len_inc;
              if (len_inc >= LEN_W'(LITERAL_MAX)) begin
                // Store full: emit the whole literal.
                q_push_o     = 1'b1;
                q_cmd_o.kind = CMD_LIT;
                q_cmd_o.len  = len_inc;
                q_cmd_o.ctrl = lit_ctrl(len_inc);
                mode_d       = MODE_IDLE;
                recent_d     = NONE_MARK;
                earlier_d    = NONE_MARK;
              end
            end
          end
          default: begin
            // Idle: start a literal.
            mode_d     = MODE_LIT;
            wr_o.we[0] = 1'b1;
            wr_o.row   = '0;
            recent_d   = in_ext;
            len_d      = LEN_W'(1);
          end
        endcase
      end
    end

    // Busy from the literal push until its last store read is issued.
    lit_busy_d = lit_busy_q;
    if (lit_done_i) begin
      lit_busy_d = 1'b0;
    end
    if (q_push_o && q_cmd_o.kind == CMD_LIT) begin
      lit_busy_d = 1'b1;
    end
  end

  // Mode and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      recent_q   <= NONE_MARK;
      earlier_q  <= NONE_MARK;
      len_q      <= '0;
      lit_busy_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      recent_q   <= recent_d;
      earlier_q  <= earlier_d;
      len_q      <= len_d;
      lit_busy_q <= lit_busy_d;
    end
  end

endmodule

// ===== design/rmrle_queue.sv =====
// ----------------------------------------------------------------------------
// Record command queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rmrle_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rmrle_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output rmrle_pkg::cmd_t head_o
);
  import rmrle_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/rmrle_back.sv =====
// ----------------------------------------------------------------------------
// Encoder back end
// Turns queued record commands into output words of up to four bytes, reading
// literal bytes from the banked store one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module rmrle_back #(
  parameter int LITERAL_MAX = 128,
  localparam int ROWS = (LITERAL_MAX + 3) / 4,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  rmrle_pkg::cmd_t                   q_head_i,
  output logic                              q_pop_o,
  output logic                              lit_done_o,
  output logic                              rd_en_o,
  output logic [AW-1:0]                     rd_row_o,
  output logic [AW-1:0]                     rd_row_prev_o,
  input  logic [rmrle_pkg::NBANKS-1:0][7:0] rd_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [31:0]                       out_data_o,
  output logic [2:0]                        out_count_o,
  output logic                              out_last_o
);
  import rmrle_pkg::*;

  localparam int NWORDS = (LITERAL_MAX + 4) / 4;
  localparam int KW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  logic [KW-1:0] k_q;
  logic          last_word, issue, c_free, b_move;
  logic [2:0]    issue_cnt;

  // Word-assembly stage (store data arrives here)
  logic          b_valid_q;
  cmd_kind_e     b_kind_q;
  logic          b_first_q, b_last_q;
  logic [2:0]    b_cnt_q;
  logic [7:0]    b_ctrl_q, b_data_q;

  // Output register
  logic          out_valid_q, out_last_q;
  logic [31:0]   out_data_q;
  logic [2:0]    out_cnt_q;

  logic [NBANKS-1:0][7:0] raw_bytes;
  logic [31:0]            word;

  // Word k of a literal holds stored bytes 4k-1 .. 4k+2.
  assign last_word = (q_head_i.kind == CMD_RUN) ||
                     (ROW_W'(k_q) == q_head_i.len[LEN_W-1:2]);
  assign c_free    = !out_valid_q || out_ready_i;
  assign b_move    = b_valid_q && c_free;
  assign issue     = q_valid_i && (!b_valid_q || b_move);

  assign q_pop_o       = issue && last_word;
  assign lit_done_o    = q_pop_o && (q_head_i.kind == CMD_LIT);
  assign rd_en_o       = issue;
  assign rd_row_o      = AW'(k_q);
  assign rd_row_prev_o = AW'(k_q - KW'(1));

  // Byte count of the word being issued
  always_comb begin
    if (q_head_i.kind == CMD_RUN) begin
      issue_cnt = 3'd2;
    end else if (last_word) begin
      issue_cnt = {1'b0, q_head_i.len[1:0]} + 3'd1;
    end else begin
      issue_cnt = 3'd4;
    end
  end

  // Assemble the output word and clear the unused upper bytes.
  always_comb begin
    if (b_kind_q == CMD_RUN) begin
      raw_bytes = {8'h00, 8'h00, b_data_q, b_ctrl_q};
    end else begin
      raw_bytes = {rd_data_i[2], rd_data_i[1], rd_data_i[0],
                   b_first_q ? b_ctrl_q : rd_data_i[3]};
    end
    for (int i = 0; i < NBANKS; i++) begin
      word[8*i +: 8] = (3'(i) < b_cnt_q) ? raw_bytes[i] : 8'h00;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        k_q <= last_word ? '0 : k_q + KW'(1);
      end
      if (issue) begin
        b_valid_q <= 1'b1;
      end else if (b_move) begin
        b_valid_q <= 1'b0;
      end
      if (b_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_kind_q  <= q_head_i.kind;
      b_first_q <= (k_q == '0);
      b_last_q  <= last_word;
      b_cnt_q   <= issue_cnt;
      b_ctrl_q  <= q_head_i.ctrl;
      b_data_q  <= q_head_i.data;
    end
    if (b_move) begin
      out_data_q <= word;
      out_cnt_q  <= b_cnt_q;
      out_last_q <= b_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== design/run_mix_rle_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// Run/literal byte encoder, top level
// Encodes a byte stream into run and literal records, up to four bytes per item.
// ----------------------------------------------------------------------------
// Throughput: one input item per cycle unless the queue is full; a literal
// record of n bytes leaves as ceil((n+1)/4) result items, one per cycle
// unless the output stalls, set by the four-bank store read port, and new
// input waits until its last store read has issued.
// Reset: asynchronous, clears mode, history, queue and output valid; the
// literal store is not cleared; bytes from unwritten entries are never output.
module run_mix_rle_byte_encoder #(
  parameter int LITERAL_MAX = 128,
  parameter int RUN_MAX     = 130
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] out_data, [34:32] out_count
  output logic        m_axis_tlast
);
  import rmrle_pkg::*;

  localparam int ROWS = (LITERAL_MAX + 3) / 4;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                   q_full, q_push, q_pop, q_valid, lit_done;
  cmd_t                   q_cmd, q_head;
  store_wr_t              store_wr;
  logic                   rd_en;
  logic [AW-1:0]          rd_row, rd_row_prev;
  logic [NBANKS-1:0][7:0] rd_data;
  logic [31:0]            out_data;
  logic [2:0]             out_count;

  // Front end: classification and store writes
  rmrle_front #(
    .LITERAL_MAX (LITERAL_MAX),
    .RUN_MAX     (RUN_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd),
    .lit_done_i (lit_done),
    .wr_o       (store_wr)
  );

  // Command queue between the two halves
  rmrle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // Literal store: one bank per byte lane, bank = byte index mod 4
  for (genvar j = 0; j < NBANKS; j++) begin : g_bank
    rmrle_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (store_wr.we[j]),
      .waddr_i (AW'(store_wr.row)),
      .wdata_i (store_wr.data),
      .re_i    (rd_en),
      .raddr_i ((j == NBANKS - 1) ? rd_row_prev : rd_row),
      .rdata_o (rd_data[j])
    );
  end

  // Back end: record output
  rmrle_back #(
    .LITERAL_MAX (LITERAL_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .lit_done_o    (lit_done),
    .rd_en_o       (rd_en),
    .rd_row_o      (rd_row),
    .rd_row_prev_o (rd_row_prev),
    .rd_data_i     (rd_data),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (out_data),
    .out_count_o   (out_count),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, out_count, out_data};

endmodule

// ===== design/rmrle_checker.sv =====
// ----------------------------------------------------------------------------
// Encoder port checker
// Watches the output stream of the encoder for malformed result items.
// ----------------------------------------------------------------------------
module rmrle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // The byte count is 1 to 4 and bytes above it are zero.
  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[34:32] == 3'd4) ||
      (m_axis_tdata[34:32] == 3'd3 && m_axis_tdata[31:24] == 8'h00) ||
      (m_axis_tdata[34:32] == 3'd2 && m_axis_tdata[31:16] == 16'h0000) ||
      (m_axis_tdata[34:32] == 3'd1 && m_axis_tdata[31:8] == 24'h000000))
    else $error("bad byte count or nonzero unused bytes");

  // Only the final item of a record may be short.
  a_short_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34:32] != 3'd4 |-> m_axis_tlast)
    else $error("short result item not marked last");

endmodule

bind run_mix_rle_byte_encoder rmrle_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the run/literal byte encoder
// Drives raw bytes and flush commands through the input stream, mirrors
// the encoder's records in a scoreboard and checks every packed output item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rmrle_pkg::*;

  localparam int LIT_LIMIT   = 128;
  localparam int RUN_LIMIT   = 130;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int END_WAIT    = 20;
  localparam int ITEM_TARGET = 150;

  // Command codes carried in tuser
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // Encoder mode as mirrored by the scoreboard
  typedef enum logic [1:0] {
    ENC_IDLE = 2'd0,
    ENC_LIT  = 2'd1,
    ENC_RUN  = 2'd2
  } enc_mode_e;

  // One packed output item
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } enc_word_t;

  // Scoreboard: tracks the encoder state and holds the words still owed.
  class rle_encoder_mirror;
    enc_mode_e   mode;
    logic [8:0]  last_b;
    logic [8:0]  prev_b;
    logic [7:0]  span_len;
    logic [7:0]  wr_pos;
    logic [7:0]  lit_buf[LIT_LIMIT];
    logic [7:0]  emitted[$];
    enc_word_t   owed_words[$];
    int          n_errors;

    function new();
      mode     = ENC_IDLE;
      last_b   = NONE_MARK;
      prev_b   = NONE_MARK;
      span_len = '0;
      wr_pos   = '0;
      n_errors = 0;
    endfunction

    function void put_run();
      logic [7:0] ctrl;
      ctrl = span_len - 8'd3;
      emitted.push_back(RUN_FLAG | (ctrl & {1'b0, CTRL_MASK}));
      emitted.push_back(last_b[7:0]);
    endfunction

    function void put_literal(input logic [7:0] n);
      logic [7:0] ctrl;
      ctrl = n - 8'd1;
      emitted.push_back(ctrl & {1'b0, CTRL_MASK});
      for (int i = 0; i < int'(n) && i < LIT_LIMIT; i++) begin
        emitted.push_back(lit_buf[i]);
      end
    endfunction

    function void go_idle();
      mode   = ENC_IDLE;
      last_b = NONE_MARK;
      prev_b = NONE_MARK;
    endfunction

    function void start_lit(input logic [7:0] b);
      mode       = ENC_LIT;
      lit_buf[0] = b;
      last_b     = {1'b0, b};
      span_len   = 8'd1;
      wr_pos     = 8'd1;
    endfunction

    // Note an accepted input item and queue the words it produces.
    function void take_input(input logic func, input logic [7:0] b);
      enc_word_t w;
      int        nres;
      int        p;
      emitted.delete();
      if (func == FUNC_FLUSH) begin
        if (mode == ENC_RUN) put_run();
        else if (mode == ENC_LIT) put_literal(span_len);
        go_idle();
      end else begin
        case (mode)
          ENC_RUN: begin
            if ({1'b0, b} != last_b) begin
              put_run();
              start_lit(b);
            end else begin
              span_len = span_len + 8'd1;
              if (span_len >= RUN_LIMIT) begin
                put_run();
                go_idle();
              end
            end
          end
          ENC_LIT: begin
            // Third equal byte turns the tail of the literal into a run.
            if ({1'b0, b} == last_b && {1'b0, b} == prev_b) begin
              mode = ENC_RUN;
              if (span_len > 8'd2) put_literal(span_len - 8'd2);
              span_len = 8'd3;
            end else begin
              prev_b = last_b;
              last_b = {1'b0, b};
              if (wr_pos < LIT_LIMIT) lit_buf[wr_pos[6:0]] = b;
              span_len = span_len + 8'd1;
              wr_pos   = wr_pos + 8'd1;
              if (span_len >= LIT_LIMIT) begin
                put_literal(span_len);
                go_idle();
              end
            end
          end
          default: start_lit(b);
        endcase
      end

      // Pack four bytes per word, first byte lowest.
      nres = (emitted.size() + 3) / 4;
      for (int k = 0; k < nres; k++) begin
        w = '0;
        for (int i = 0; i < 4; i++) begin
          p = k * 4 + i;
          if (p < emitted.size()) begin
            w.data[8*i +: 8] = emitted[p];
            w.count = w.count + 3'd1;
          end
        end
        w.last = (k + 1 == nres);
        owed_words.push_back(w);
      end
    endfunction

    // Compare an accepted output item with the oldest owed word.
    function void check_word(input logic [31:0] data, input logic [2:0] count,
                             input logic last);
      enc_word_t w;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected output item: data %h count %0d last %0b",
                 $time, data, count, last);
        n_errors++;
        return;
      end
      w = owed_words.pop_front();
      if (data !== w.data) begin
        $display("%0t: out_data mismatch: expected %h, actual %h", $time, w.data, data);
        n_errors++;
      end
      if (count !== w.count) begin
        $display("%0t: out_count mismatch: expected %0d, actual %0d",
                 $time, w.count, count);
        n_errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, w.last, last);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = FUNC_ENCODE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  rle_encoder_mirror mirror = new();
  int  n_sent   = 0;
  int  n_cycles = 0;
  bit  src_calm = 1'b0;
  bit  snk_calm = 1'b0;

  run_mix_rle_byte_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on the whole run
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Observe both handshakes at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) mirror.take_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        mirror.check_word(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
      end
    end
  end

  // Output back-pressure: short stalls mostly, a few long ones.
  initial begin
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (snk_calm || r < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 20);
      end
    end
  end

  // Present one input item, after a random gap, and wait until it is taken.
  task automatic send_item(input logic func, input logic [7:0] b);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!src_calm) begin
      if (r >= 92) gap = $urandom_range(8, 30);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic send_run(input logic [7:0] b, input int len);
    for (int i = 0; i < len; i++) send_item(FUNC_ENCODE, b);
  endtask

  // Literal with no two neighbors equal, so it never forms a run by itself.
  task automatic send_literal(input int len);
    logic [7:0] b;
    logic [7:0] prev;
    prev = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == prev) b = b + 8'd1;
      send_item(FUNC_ENCODE, b);
      prev = b;
    end
  endtask

  // Check away from the rising edge, after the monitor has noted the last item.
  task automatic wait_all_out();
    @(negedge clk_i);
    while (mirror.owed_words.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Reset and stimulus
  initial begin
    int  kind;
    bit  did_long_lit;
    bit  did_long_run;
    logic [7:0] b;
    did_long_lit = 1'b0;
    did_long_run = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: flush while idle, field extremes, run after short literals.
    send_item(FUNC_FLUSH, 8'hFF);
    send_item(FUNC_ENCODE, 8'h00);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_FLUSH, 8'h00);
    send_run(8'hFF, 3);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_ENCODE, 8'h12);
    send_run(8'h34, 4);
    send_item(FUNC_ENCODE, 8'h56);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_ENCODE, 8'hA5);
    send_run(8'h5A, 2);
    send_item(FUNC_FLUSH, 8'h00);
    for (int i = 1; i <= 5; i++) send_item(FUNC_ENCODE, 8'(i));
    send_item(FUNC_FLUSH, 8'h00);

    // Hold off until every owed word has come out.
    s_axis_tvalid <= 1'b0;
    wait_all_out();

    // Random: mostly well-formed runs and literals, some noise.
    while (n_sent < ITEM_TARGET || !did_long_lit || !did_long_run) begin
      src_calm = ($urandom_range(0, 99) < 20);
      snk_calm = ($urandom_range(0, 99) < 20);
      kind = $urandom_range(0, 99);
      if (n_sent >= ITEM_TARGET) kind = did_long_lit ? 88 : 91;
      if (kind < 35) begin
        // Short literal, sometimes from a tiny alphabet to provoke runs
        if (kind < 15) begin
          repeat ($urandom_range(1, 12)) send_item(FUNC_ENCODE, 8'($urandom_range(0, 3)));
        end else begin
          send_literal($urandom_range(1, 12));
        end
      end else if (kind < 65) begin
        send_run(8'($urandom_range(0, 255)), $urandom_range(1, 12));
      end else if (kind < 75) begin
        send_run(8'($urandom_range(0, 255)), $urandom_range(10, 40));
      end else if (kind < 85) begin
        send_item(FUNC_FLUSH, 8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        send_run(8'($urandom_range(0, 255)), $urandom_range(125, 140));
        did_long_run = 1'b1;
      end else if (kind < 93) begin
        send_literal($urandom_range(120, 135));
        did_long_lit = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom_range(0, 255));
          send_item(logic'($urandom_range(0, 1)), b);
        end
      end
      if ($urandom_range(0, 99) < 3) begin
        s_axis_tvalid <= 1'b0;
        wait_all_out();
      end
    end
    send_item(FUNC_FLUSH, 8'h00);
    s_axis_tvalid <= 1'b0;
    snk_calm = 1'b0;

    wait_all_out();
    repeat (END_WAIT) @(posedge clk_i);
    if (mirror.n_errors == 0 && mirror.owed_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
